### rtl/moving_average_crossover_region_unit_macros.svh
// Assertion macros shared by the moving average crossover region RTL.
`ifndef MOVING_AVERAGE_CROSSOVER_REGION_UNIT_MACROS_SVH
`define MOVING_AVERAGE_CROSSOVER_REGION_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define MACR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define MACR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/macr_pkg.sv
// Shared constants for the moving average crossover region unit.
`timescale 1ns / 1ps

package macr_pkg;

    // Default sizing
    localparam int HISTORY_DEPTH_DEF = 256;
    localparam int PRICE_BITS_DEF    = 32;

    // Port field widths
    localparam int IN_PRICE_BITS  = 32;
    localparam int AVG_BITS       = 32;
    localparam int SHORT_REG_BITS = 8;
    localparam int LONG_REG_BITS  = 9;
    localparam int CFG_DATA_BITS  = 9;
    localparam int CFG_INDEX_BITS = 1;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_SHORT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_LONG  = 1'b1;

    // Register reset values
    localparam logic [SHORT_REG_BITS-1:0] SHORT_WIN_RESET = 8'd5;
    localparam logic [LONG_REG_BITS-1:0]  LONG_WIN_RESET  = 9'd20;

    // Trend region codes
    localparam logic signed [1:0] REGION_EQUAL = 2'sb00;
    localparam logic signed [1:0] REGION_ABOVE = 2'sb01;
    localparam logic signed [1:0] REGION_BELOW = 2'sb11;

endpackage

### rtl/macr_hist_mem.sv
// Price history memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module macr_hist_mem #(
    parameter int DEPTH = macr_pkg::HISTORY_DEPTH_DEF,
    parameter int WIDTH = macr_pkg::PRICE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // Store the incoming price
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read both leaving prices into the registered read ports
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### rtl/macr_div.sv
// Restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps

module macr_div #(
    parameter int DIVIDEND_BITS = 40,
    parameter int DIVISOR_BITS  = 9,
    parameter int QUO_BITS      = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    input  logic [DIVISOR_BITS-1:0]  i_divisor,
    output logic                     o_busy,
    output logic [QUO_BITS-1:0]      o_quotient
);

    localparam int CNT_BITS = $clog2(QUO_BITS + 1);

    logic [CNT_BITS-1:0]     r_cnt;
    logic [CNT_BITS-1:0]     n_cnt;
    logic [DIVISOR_BITS-1:0] r_rem;
    logic [DIVISOR_BITS-1:0] n_rem;
    logic [DIVISOR_BITS-1:0] r_dvs;
    logic [QUO_BITS-1:0]     r_shift;
    logic [QUO_BITS-1:0]     n_shift;
    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS:0]   diff;
    logic                    fits;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_shift[QUO_BITS-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
        n_rem   = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        n_shift = {r_shift[QUO_BITS-2:0], fits};
        n_cnt   = r_cnt - CNT_BITS'(1);
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_BITS'(QUO_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= n_cnt;
        end
    end

    // Remainder and quotient datapath; upper dividend bits already lie below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= DIVISOR_BITS'(i_dividend[DIVIDEND_BITS-1:QUO_BITS]);
            r_shift <= i_dividend[QUO_BITS-1:0];
            r_dvs   <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem   <= n_rem;
            r_shift <= n_shift;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_shift;

endmodule

### rtl/moving_average_crossover_region_unit.sv
// Dual simple moving average crossover region unit, top level.
// One price word enters at a time and one result word leaves for each; the
// averages come from the two window dividers that resolve one quotient bit per
// cycle. The input is stalled while a price is in work; a finished result waits
// in the output register, so the next price is taken while it is still stalled
// downstream. The price history is one memory with two read ports (the prices
// leaving the short and long windows) and one write port, and needs no clearing
// pass after reset: a read entry is used only once a window has filled since the
// last restart. o_cfg_ready is always high; every register write restarts the
// stream (sums, sample count and write pointer clear). A window register of zero
// acts as one and a window above HISTORY_DEPTH acts as HISTORY_DEPTH.
`timescale 1ns / 1ps
`include "moving_average_crossover_region_unit_macros.svh"

module moving_average_crossover_region_unit #(
    parameter int HISTORY_DEPTH = macr_pkg::HISTORY_DEPTH_DEF,
    parameter int PRICE_BITS    = macr_pkg::PRICE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [macr_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [macr_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // Price input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [macr_pkg::IN_PRICE_BITS-1:0]    i_price,
    // Result output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [macr_pkg::AVG_BITS-1:0]         o_short_average,
    output logic [macr_pkg::AVG_BITS-1:0]         o_long_average,
    output logic                                  o_short_full,
    output logic                                  o_long_full,
    output logic signed [1:0]                     o_trend_region
);

    localparam int ADDR_BITS = $clog2(HISTORY_DEPTH);
    localparam int WIN_BITS  = ADDR_BITS + 1;
    localparam int SUM_BITS  = PRICE_BITS + ADDR_BITS;
    localparam int IN_EXT    = (PRICE_BITS > macr_pkg::IN_PRICE_BITS) ?
                               PRICE_BITS : macr_pkg::IN_PRICE_BITS;
    localparam int OUT_EXT   = (PRICE_BITS > macr_pkg::AVG_BITS) ?
                               PRICE_BITS : macr_pkg::AVG_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SUM  = 3'b010,
        S_DIV  = 3'b100
    } t_state;

    t_state                                r_state;
    t_state                                n_state;
    logic [macr_pkg::SHORT_REG_BITS-1:0]   r_short_win;
    logic [macr_pkg::LONG_REG_BITS-1:0]    r_long_win;
    logic [SUM_BITS-1:0]                   r_short_sum;
    logic [SUM_BITS-1:0]                   r_long_sum;
    logic [SUM_BITS-1:0]                   n_short_sum;
    logic [SUM_BITS-1:0]                   n_long_sum;
    logic [WIN_BITS-1:0]                   r_count;
    logic [WIN_BITS-1:0]                   n_count;
    logic [ADDR_BITS-1:0]                  r_wptr;
    logic [ADDR_BITS-1:0]                  n_wptr;
    logic [PRICE_BITS-1:0]                 r_price;
    logic                                  r_short_full;
    logic                                  r_long_full;
    logic                                  r_out_valid;
    logic [macr_pkg::AVG_BITS-1:0]         r_short_avg;
    logic [macr_pkg::AVG_BITS-1:0]         r_long_avg;
    logic                                  r_out_sfull;
    logic                                  r_out_lfull;
    logic signed [1:0]                     r_region;

    logic                                  cfg_wr;
    logic                                  in_acc;
    logic                                  out_load;
    logic [WIN_BITS-1:0]                   short_w;
    logic [WIN_BITS-1:0]                   long_w;
    logic [ADDR_BITS-1:0]                  short_slot;
    logic [ADDR_BITS-1:0]                  long_slot;
    logic [IN_EXT-1:0]                     price_ext;
    logic [PRICE_BITS-1:0]                 rd_short;
    logic [PRICE_BITS-1:0]                 rd_long;
    logic [SUM_BITS:0]                     short_acc;
    logic [SUM_BITS:0]                     long_acc;
    logic                                  short_drop;
    logic                                  long_drop;
    logic                                  div_start;
    logic                                  sdiv_busy;
    logic                                  ldiv_busy;
    logic [PRICE_BITS-1:0]                 short_quo;
    logic [PRICE_BITS-1:0]                 long_quo;
    logic [PRICE_BITS-1:0]                 short_mean;
    logic [PRICE_BITS-1:0]                 long_mean;
    logic [OUT_EXT-1:0]                    short_mean_ext;
    logic [OUT_EXT-1:0]                    long_mean_ext;
    logic signed [1:0]                     region;

    // Effective window sizes: zero acts as one, clamp to the history depth
    function automatic logic [WIN_BITS-1:0] eff_window(input logic [31:0] reg_val);
        logic [WIN_BITS-1:0] w;
        if (reg_val == 32'd0) begin
            w = WIN_BITS'(1);
        end else if (reg_val > 32'(HISTORY_DEPTH)) begin
            w = WIN_BITS'(HISTORY_DEPTH);
        end else begin
            w = WIN_BITS'(reg_val);
        end
        return w;
    endfunction

    // Slot of the price that leaves a window of size w
    function automatic logic [ADDR_BITS-1:0] leave_slot(input logic [ADDR_BITS-1:0] wp,
                                                        input logic [WIN_BITS-1:0] w);
        logic [WIN_BITS:0] wp_x;
        logic [WIN_BITS:0] w_x;
        logic [WIN_BITS:0] s;
        wp_x = (WIN_BITS + 1)'(wp);
        w_x  = (WIN_BITS + 1)'(w);
        if (wp_x >= w_x) begin
            s = wp_x - w_x;
        end else begin
            s = wp_x + (WIN_BITS + 1)'(HISTORY_DEPTH) - w_x;
        end
        return s[ADDR_BITS-1:0];
    endfunction

    assign short_w    = eff_window(32'(r_short_win));
    assign long_w     = eff_window(32'(r_long_win));
    assign short_slot = leave_slot(r_wptr, short_w);
    assign long_slot  = leave_slot(r_wptr, long_w);

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign div_start   = (r_state == S_SUM);
    assign out_load    = (r_state == S_DIV) && !sdiv_busy && !ldiv_busy &&
                         (!r_out_valid || !i_out_stall);

    // Sequence one price through read, sum update and divide
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_win <= macr_pkg::SHORT_WIN_RESET;
            r_long_win  <= macr_pkg::LONG_WIN_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                macr_pkg::CFG_IDX_SHORT: begin
                    r_short_win <= i_cfg_data[macr_pkg::SHORT_REG_BITS-1:0];
                end
                macr_pkg::CFG_IDX_LONG: begin
                    r_long_win <= i_cfg_data[macr_pkg::LONG_REG_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Latch the accepted price at the datapath width
    assign price_ext = IN_EXT'(i_price);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_price <= price_ext[PRICE_BITS-1:0];
        end
    end

    // History memory
    macr_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (PRICE_BITS)
    ) u_hist (
        .i_clk       (i_clk),
        .i_wr_en     (div_start),
        .i_wr_addr   (r_wptr),
        .i_wr_data   (r_price),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (short_slot),
        .i_rd_addr_b (long_slot),
        .o_rd_data_a (rd_short),
        .o_rd_data_b (rd_long)
    );

    // Add the new price, drop the leaving one once the window has filled
    always_comb begin
        short_drop  = (r_count >= short_w);
        long_drop   = (r_count >= long_w);
        short_acc   = (SUM_BITS + 1)'(r_short_sum) + (SUM_BITS + 1)'(r_price)
                      - (short_drop ? (SUM_BITS + 1)'(rd_short) : '0);
        long_acc    = (SUM_BITS + 1)'(r_long_sum) + (SUM_BITS + 1)'(r_price)
                      - (long_drop ? (SUM_BITS + 1)'(rd_long) : '0);
        n_short_sum = short_acc[SUM_BITS-1:0];
        n_long_sum  = long_acc[SUM_BITS-1:0];
        n_count     = (r_count < WIN_BITS'(HISTORY_DEPTH)) ? r_count + WIN_BITS'(1) : r_count;
        n_wptr      = (r_wptr == ADDR_BITS'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + ADDR_BITS'(1);
    end

    // Stream state; a register write restarts it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_short_sum <= '0;
            r_long_sum  <= '0;
            r_count     <= '0;
            r_wptr      <= '0;
        end else if (div_start) begin
            r_short_sum <= n_short_sum;
            r_long_sum  <= n_long_sum;
            r_count     <= n_count;
            r_wptr      <= n_wptr;
        end
    end

    // Full flags of the item in work
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_short_full <= (n_count >= short_w);
            r_long_full  <= (n_count >= long_w);
        end
    end

    // Window dividers
    macr_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (WIN_BITS),
        .QUO_BITS      (PRICE_BITS)
    ) u_short_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_short_sum),
        .i_divisor  (short_w),
        .o_busy     (sdiv_busy),
        .o_quotient (short_quo)
    );

    macr_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (WIN_BITS),
        .QUO_BITS      (PRICE_BITS)
    ) u_long_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_long_sum),
        .i_divisor  (long_w),
        .o_busy     (ldiv_busy),
        .o_quotient (long_quo)
    );

    // Zero the averages of windows not yet full and compare them
    always_comb begin
        short_mean     = r_short_full ? short_quo : '0;
        long_mean      = r_long_full ? long_quo : '0;
        short_mean_ext = OUT_EXT'(short_mean);
        long_mean_ext  = OUT_EXT'(long_mean);
        region         = macr_pkg::REGION_EQUAL;
        if (r_short_full && r_long_full) begin
            if (short_mean > long_mean) begin
                region = macr_pkg::REGION_ABOVE;
            end else if (short_mean < long_mean) begin
                region = macr_pkg::REGION_BELOW;
            end
        end
    end

    // Output register: load a finished word, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_short_avg <= short_mean_ext[macr_pkg::AVG_BITS-1:0];
            r_long_avg  <= long_mean_ext[macr_pkg::AVG_BITS-1:0];
            r_out_sfull <= r_short_full;
            r_out_lfull <= r_long_full;
            r_region    <= region;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_short_average = r_short_avg;
    assign o_long_average  = r_long_avg;
    assign o_short_full    = r_out_sfull;
    assign o_long_full     = r_out_lfull;
    assign o_trend_region  = r_region;

    // Checks
    `MACR_ASSERT_NEXT(a_sum_after_accept, i_clk, i_rst_n, in_acc, r_state == S_SUM, "accepted price did not reach the sum update")
    `MACR_ASSERT_NEXT(a_div_after_sum, i_clk, i_rst_n, div_start, sdiv_busy && ldiv_busy, "dividers not started after the sum update")
    `MACR_ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, cfg_wr, r_count == '0 && r_wptr == '0, "register write did not restart the stream")
    `MACR_ASSERT_SAME(a_region_needs_full, i_clk, i_rst_n, o_out_valid && o_trend_region != macr_pkg::REGION_EQUAL, o_short_full && o_long_full, "trend region set with a window not full")

endmodule
